// ----- rtl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants for the cubic Bezier evaluator pipeline.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int TW     = 17;  // parameter t, unsigned Q1.16
  localparam int PW     = 32;  // coordinates, signed Q16.16
  localparam int VW     = 35;  // first derivative, signed Q19.16
  localparam int AW     = 37;  // second derivative, signed Q21.16
  localparam int ADDR_W = 5;   // eight 32-bit registers

  localparam logic [TW-1:0] T_ONE = 17'h10000;

  // rounding offsets: one half of the dropped fraction
  localparam logic [81:0] POS_RND = 82'h8000_0000_0000;
  localparam logic [67:0] VEL_RND = 68'h8000_0000;
  localparam logic [53:0] ACC_RND = 54'h8000;

  typedef enum logic [2:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_e;

  // powers of t and u = 1 - t, shared by both axes, tagged by stage
  typedef struct packed {
    logic [16:0] t1;   // stage 1
    logic [16:0] u1;
    logic [17:0] t3;   // 3t
    logic [17:0] u3;   // 3u
    logic [32:0] uu2;  // stage 2
    logic [30:0] ut2;
    logic [32:0] tt2;
    logic [32:0] uu3;  // stage 3
    logic [32:0] tt3;
  } pow_t;

endpackage

// ----- rtl/cbe_axis.sv -----
// ----------------------------------------------------------------------------
// cbe_axis
// One coordinate axis of the evaluator: position, first and second
// derivative from the shared powers of t, five register stages.
// ----------------------------------------------------------------------------
module cbe_axis (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cbe_pkg::pow_t                   pw_i,
  input  logic signed [cbe_pkg::PW-1:0]   p0_i,
  input  logic signed [cbe_pkg::PW-1:0]   p1_i,
  input  logic signed [cbe_pkg::PW-1:0]   p2_i,
  input  logic signed [cbe_pkg::PW-1:0]   p3_i,
  output logic signed [cbe_pkg::PW-1:0]   pos_o,
  output logic signed [cbe_pkg::VW-1:0]   vel_o,
  output logic signed [cbe_pkg::AW-1:0]   acc_o
);
  import cbe_pkg::*;

  // control point differences, refreshed every cycle
  logic signed [32:0] d10_q, d21_q, d32_q;
  logic signed [33:0] e0_q, e1_q;

  // stage 2
  logic signed [49:0] m0_full, m3_full;
  logic signed [50:0] m1_full, m2_full;
  logic signed [51:0] g0_full, g1_full;
  logic signed [47:0] m0_q, m3_q;
  logic signed [49:0] m1_q, m2_q;
  logic signed [50:0] g0_q, g1_q;

  // stage 3
  logic signed [49:0] a_q, b_q;
  logic signed [50:0] gs_q;
  logic signed [66:0] v0_full, v2_full;
  logic signed [64:0] v1_full;
  logic signed [65:0] v0_q, v2_q;
  logic signed [63:0] v1_q;

  // stage 4
  logic signed [59:0] pal_full, pbl_full;
  logic signed [58:0] pah_full, pbh_full;
  logic        [56:0] pal_q, pbl_q;
  logic        [57:0] pah_q, pbh_q;
  logic signed [65:0] vs_q;
  logic        [53:0] acc6;
  logic signed [AW-1:0] acc4_q;

  // stage 5
  logic [82:0] pa_full, pb_full;
  logic [81:0] pa_q, pb_q;
  logic [67:0] vel3;
  logic signed [VW-1:0] vel5_q;
  logic signed [AW-1:0] acc5_q;

  // stage 6
  logic [81:0] pos_full;
  logic signed [PW-1:0] pos_q;
  logic signed [VW-1:0] vel_q;
  logic signed [AW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d10_q <= '0;
      d21_q <= '0;
      d32_q <= '0;
      e0_q  <= '0;
      e1_q  <= '0;
    end else begin
      d10_q <= {p1_i[31], p1_i} - {p0_i[31], p0_i};
      d21_q <= {p2_i[31], p2_i} - {p1_i[31], p1_i};
      d32_q <= {p3_i[31], p3_i} - {p2_i[31], p2_i};
      e0_q  <= {{2{p2_i[31]}}, p2_i} - {p1_i[31], p1_i, 1'b0} + {{2{p0_i[31]}}, p0_i};
      e1_q  <= {{2{p3_i[31]}}, p3_i} - {p2_i[31], p2_i, 1'b0} + {{2{p1_i[31]}}, p1_i};
    end
  end

  // position is regrouped as uu*(u*P0 + 3t*P1) + tt*(3u*P2 + t*P3)
  assign m0_full = 50'($signed({1'b0, pw_i.u1})) * 50'(p0_i);
  assign m1_full = 51'($signed({1'b0, pw_i.t3})) * 51'(p1_i);
  assign m2_full = 51'($signed({1'b0, pw_i.u3})) * 51'(p2_i);
  assign m3_full = 50'($signed({1'b0, pw_i.t1})) * 50'(p3_i);
  assign g0_full = 52'($signed({1'b0, pw_i.u1})) * 52'(e0_q);
  assign g1_full = 52'($signed({1'b0, pw_i.t1})) * 52'(e1_q);

  assign v0_full = 67'($signed({1'b0, pw_i.uu2})) * 67'(d10_q);
  assign v1_full = 65'($signed({1'b0, pw_i.ut2})) * 65'(d21_q);
  assign v2_full = 67'($signed({1'b0, pw_i.tt2})) * 67'(d32_q);

  // split the 50-bit sums so each product stays near 32x32
  assign pal_full = 60'($signed({1'b0, pw_i.uu3})) * 60'($signed({1'b0, a_q[24:0]}));
  assign pah_full = 59'($signed({1'b0, pw_i.uu3})) * 59'($signed(a_q[49:25]));
  assign pbl_full = 60'($signed({1'b0, pw_i.tt3})) * 60'($signed({1'b0, b_q[24:0]}));
  assign pbh_full = 59'($signed({1'b0, pw_i.tt3})) * 59'($signed(b_q[49:25]));

  // 6*gs plus one half, taken at 2^-16
  assign acc6 = {gs_q[50], gs_q, 2'b00} + {{2{gs_q[50]}}, gs_q, 1'b0} + ACC_RND;

  assign pa_full = {pah_q, 25'd0} + {26'd0, pal_q};
  assign pb_full = {pbh_q, 25'd0} + {26'd0, pbl_q};
  // 3*vs plus one half, taken at 2^-16
  assign vel3    = {vs_q[65], vs_q, 1'b0} + {{2{vs_q[65]}}, vs_q} + VEL_RND;

  assign pos_full = pa_q + pb_q + POS_RND;

  always_ff @(posedge clk_i) begin
    // stage 2
    m0_q <= m0_full[47:0];
    m1_q <= m1_full[49:0];
    m2_q <= m2_full[49:0];
    m3_q <= m3_full[47:0];
    g0_q <= g0_full[50:0];
    g1_q <= g1_full[50:0];
    // stage 3
    a_q  <= {{2{m0_q[47]}}, m0_q} + m1_q;
    b_q  <= m2_q + {{2{m3_q[47]}}, m3_q};
    gs_q <= g0_q + g1_q;
    v0_q <= v0_full[65:0];
    v1_q <= v1_full[63:0];
    v2_q <= v2_full[65:0];
    // stage 4
    pal_q  <= pal_full[56:0];
    pah_q  <= pah_full[57:0];
    pbl_q  <= pbl_full[56:0];
    pbh_q  <= pbh_full[57:0];
    vs_q   <= v0_q + {v1_q[63], v1_q, 1'b0} + v2_q;
    acc4_q <= acc6[52:16];
    // stage 5
    pa_q   <= pa_full[81:0];
    pb_q   <= pb_full[81:0];
    vel5_q <= vel3[66:32];
    acc5_q <= acc4_q;
    // stage 6
    pos_q  <= pos_full[79:48];
    vel_q  <= vel5_q;
    acc_q  <= acc5_q;
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;
  assign acc_o = acc_q;

endmodule

// ----- rtl/cubic_bezier_evaluator.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_evaluator
// Evaluates a planar cubic Bezier curve and its first two derivatives at t.
// ----------------------------------------------------------------------------
// Usage:
//   Control points P0..P3 (x and y, signed Q16.16) are written over the APB
//   port at byte addresses 0x00..0x1C; reads return the stored values.
//   Write them only while no evaluation is in flight.
//   Raise start with param_t_i (unsigned Q1.16, values above 1.0 clamp to
//   1.0); the transaction is taken at the clock edge where busy is low.
//   busy never rises, so one t can be taken every cycle.
//   Six register stages: the result for a taken t is on the result ports
//   with valid_o high for exactly one cycle once it leaves the last stage.
//   Throughput is one result per cycle; results leave in request order.
//   The depth is set by the 33x50 position product, which is split into two
//   partial products and summed over two stages.
//   There is no back-pressure on the result side: a result not taken in its
//   valid_o cycle is gone.
//   Reset clears the control points to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cbe_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // request
  input  logic                               start,
  output logic                               busy,
  input  logic [cbe_pkg::TW-1:0]             param_t_i,
  // result
  output logic                               valid_o,
  output logic signed [cbe_pkg::PW-1:0]      pos_x_o,
  output logic signed [cbe_pkg::PW-1:0]      pos_y_o,
  output logic signed [cbe_pkg::VW-1:0]      vel_x_o,
  output logic signed [cbe_pkg::VW-1:0]      vel_y_o,
  output logic signed [cbe_pkg::AW-1:0]      acc_x_o,
  output logic signed [cbe_pkg::AW-1:0]      acc_y_o
);
  import cbe_pkg::*;

  logic [PW-1:0] p_q [8];
  logic          cfg_wr;
  logic          in_acc;
  logic [5:0]    vld_q;

  logic [TW-1:0] t_sat, u_val;
  logic [17:0]   t3_val, u3_val;
  logic [TW-1:0] t1_q, u1_q;
  logic [17:0]   t3_q, u3_q;
  logic [33:0]   uu_full, ut_full, tt_full;
  logic [32:0]   uu2_q, tt2_q, uu3_q, tt3_q;
  logic [30:0]   ut2_q;
  pow_t          pw;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign in_acc = start & ~busy;
  assign prdata = p_q[paddr[ADDR_W-1:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) p_q[i] <= '0;
    end else if (cfg_wr) begin
      p_q[paddr[ADDR_W-1:2]] <= pwdata;
    end
  end

  // valid bits travel alongside the payload stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], in_acc};
    end
  end

  // stage 1: clamp t, form u = 1 - t and the tripled values
  always_comb begin
    t_sat  = (param_t_i > T_ONE) ? T_ONE : param_t_i;
    u_val  = T_ONE - t_sat;
    t3_val = {1'b0, t_sat} + {t_sat, 1'b0};
    u3_val = {1'b0, u_val} + {u_val, 1'b0};
  end

  assign uu_full = {17'd0, u1_q} * {17'd0, u1_q};
  assign ut_full = {17'd0, u1_q} * {17'd0, t1_q};
  assign tt_full = {17'd0, t1_q} * {17'd0, t1_q};

  always_ff @(posedge clk_i) begin
    t1_q  <= t_sat;
    u1_q  <= u_val;
    t3_q  <= t3_val;
    u3_q  <= u3_val;
    uu2_q <= uu_full[32:0];
    ut2_q <= ut_full[30:0];
    tt2_q <= tt_full[32:0];
    uu3_q <= uu2_q;
    tt3_q <= tt2_q;
  end

  always_comb begin
    pw.t1  = t1_q;
    pw.u1  = u1_q;
    pw.t3  = t3_q;
    pw.u3  = u3_q;
    pw.uu2 = uu2_q;
    pw.ut2 = ut2_q;
    pw.tt2 = tt2_q;
    pw.uu3 = uu3_q;
    pw.tt3 = tt3_q;
  end

  cbe_axis u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pw_i   (pw),
    .p0_i   ($signed(p_q[REG_P0_X])),
    .p1_i   ($signed(p_q[REG_P1_X])),
    .p2_i   ($signed(p_q[REG_P2_X])),
    .p3_i   ($signed(p_q[REG_P3_X])),
    .pos_o  (pos_x_o),
    .vel_o  (vel_x_o),
    .acc_o  (acc_x_o)
  );

  cbe_axis u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pw_i   (pw),
    .p0_i   ($signed(p_q[REG_P0_Y])),
    .p1_i   ($signed(p_q[REG_P1_Y])),
    .p2_i   ($signed(p_q[REG_P2_Y])),
    .p3_i   ($signed(p_q[REG_P3_Y])),
    .pos_o  (pos_y_o),
    .vel_o  (vel_y_o),
    .acc_o  (acc_y_o)
  );

  assign valid_o = vld_q[5];

  // every accepted transaction yields exactly one result at the pipeline output
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##6 valid_o)
    else $error("result missing six cycles after accepted request");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_acc, 6))
    else $error("result without a matching request");

  // t and u must stay complementary after clamping
  a_tu_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (({1'b0, t1_q} + {1'b0, u1_q}) == {1'b0, T_ONE}))
    else $error("t + u differs from one");

  // (u + t)^2 = 1 checks the three square products together
  a_pow_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (({1'b0, uu2_q} + {2'b00, ut2_q, 1'b0} + {1'b0, tt2_q})
                  == 34'h1_0000_0000))
    else $error("power products inconsistent");

endmodule
